// ===== hw/rtl/bats_pkg.sv =====
`timescale 1ns / 1ps

package bats_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_ERASE  = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;
  localparam logic [2:0] REQ_MANUAL = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // ring modes
  localparam logic [1:0] MODE_WEEKDAYS = 2'd1;
  localparam logic [1:0] MODE_DAILY    = 2'd2;
  localparam logic [2:0] LAST_WORKDAY  = 3'd5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RING_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SECONDS = 1'b1;
  localparam logic [3:0] RING_SECONDS_RST = 4'd5;

  localparam logic [7:0] BCD_MIN_SEC_MAX = 8'h59;
  localparam logic [7:0] BCD_HOUR_MAX    = 8'h23;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic [2:0] weekday;
    logic [7:0] entry_index;
    logic       manual_on;
  } req_t;

  typedef struct packed {
    logic       bell_on;
    logic [1:0] status;
    logic [5:0] now_hour;
    logic [6:0] now_minute;
    logic [6:0] now_second;
  } rsp_t;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN,
    S_DONE
  } state_t;

  // sort key hour*0x60 + minute, built from shifts
  function automatic logic [12:0] entry_key(input logic [5:0] h, input logic [6:0] m);
    return 13'({h, 6'b0}) + 13'({h, 5'b0}) + 13'(m);
  endfunction

  // one BCD increment; bit 8 flags a wrap past limit (value then zero)
  function automatic logic [8:0] bcd_step(input logic [7:0] v, input logic [7:0] limit);
    logic [7:0] x;
    x = v + ((v[3:0] == 4'h9) ? 8'd7 : 8'd1);
    if (x[7:4] > 4'h9) x = x + 8'h60;
    if (x > limit) return {1'b1, 8'h00};
    return {1'b0, x};
  endfunction

endpackage

// ===== hw/rtl/bcd_alarm_table_bell_scheduler_core.sv =====
`timescale 1ns / 1ps

// BCD clock with a sorted alarm table driving a bell. Each input transaction
// (tick, set time, add entry, erase entry, clear table, manual ring) yields
// exactly one result with the bell state, a status and the clock after it.
// The table sits in a memory with one read and one write port, walked by a
// small sequencer, one transaction at a time. Each transaction makes one pass
// over the valid entries to find a match, after a sorted add or an erase has
// moved the entries behind the insert or erase point by one place.
// Reset empties the table at once through the fill count; no clearing pass.
module bcd_alarm_table_bell_scheduler_core
  import bats_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rsp_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t state, state_next;
  req_t   req;

  logic [6:0] clk_sec, clk_sec_next;
  logic [6:0] clk_min, clk_min_next;
  logic [5:0] clk_hour, clk_hour_next;
  logic [2:0] clk_wday, clk_wday_next;
  logic       manual_ring, manual_ring_next;
  logic [1:0] ring_mode;
  logic [3:0] ring_seconds;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [1:0]       status, status_next;
  logic             match, match_next;
  logic             scan_vld, scan_vld_next;
  logic             out_valid_next;
  rsp_t             out_data_next;

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data, wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic       full, idx_bad, idx_used, idx_moves, del_more, key_gt, out_free, day_ok;
  logic [8:0] step_s, step_m, step_h;
  entry_t     new_entry;

  assign new_entry = '{hour: req.hour_bcd, minute: req.minute_bcd};
  assign full      = (count == CNT_W'(TABLE_ENTRIES));
  assign idx_bad   = ({1'b0, req.entry_index} >= 9'(TABLE_ENTRIES));
  assign idx_used  = ({1'b0, req.entry_index} < 9'(count));
  assign idx_moves = ({1'b0, req.entry_index} + 9'd1) < 9'(count);
  assign del_more  = ({1'b0, pos} + (CNT_W + 1)'(2)) < {1'b0, count};
  assign key_gt    = entry_key(rd_data.hour, rd_data.minute) >
                     entry_key(new_entry.hour, new_entry.minute);
  assign out_free  = !out_valid || !out_stall;
  assign day_ok    = (ring_mode == MODE_WEEKDAYS && clk_wday <= LAST_WORKDAY) ||
                     (ring_mode == MODE_DAILY);

  assign step_s = bcd_step({1'b0, clk_sec}, BCD_MIN_SEC_MAX);
  assign step_m = bcd_step({1'b0, clk_min}, BCD_MIN_SEC_MAX);
  assign step_h = bcd_step({2'b0, clk_hour}, BCD_HOUR_MAX);

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (req.req_type)
          REQ_ADD: begin
            if (full)            state_next = S_SCAN;
            else if (count == '0) state_next = S_INS_PUT;
            else                 state_next = S_INS_RD;
          end
          REQ_ERASE: begin
            if (!idx_bad && idx_used && idx_moves) state_next = S_DEL_RD;
            else                                   state_next = S_SCAN;
          end
          default: state_next = S_SCAN;
        endcase
      end
      S_INS_RD:  state_next = S_INS_CMP;
      S_INS_CMP: state_next = (key_gt && pos > CNT_W'(1)) ? S_INS_RD : S_INS_PUT;
      S_INS_PUT: state_next = S_SCAN;
      S_DEL_RD:  state_next = S_DEL_WR;
      S_DEL_WR:  state_next = del_more ? S_DEL_RD : S_SCAN;
      S_SCAN:    if (pos >= count && !scan_vld) state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clk_sec_next     = clk_sec;
    clk_min_next     = clk_min;
    clk_hour_next    = clk_hour;
    clk_wday_next    = clk_wday;
    manual_ring_next = manual_ring;
    count_next       = count;
    pos_next         = pos;
    status_next      = status;
    match_next       = match;
    scan_vld_next    = scan_vld;
    out_valid_next   = out_valid && out_stall;
    out_data_next    = out_data;
    rd_addr          = pos[IDX_W-1:0];
    wr_addr          = pos[IDX_W-1:0];
    wr_data          = new_entry;
    wr_en            = 1'b0;

    unique case (state)
      S_IDLE: status_next = ST_OK;
      S_EXEC: begin
        unique case (req.req_type)
          REQ_TICK: begin
            clk_sec_next = step_s[6:0];
            if (step_s[8]) begin
              clk_min_next = step_m[6:0];
              if (step_m[8]) clk_hour_next = step_h[5:0];
            end
          end
          REQ_SET: begin
            clk_hour_next = req.hour_bcd;
            clk_min_next  = req.minute_bcd;
            clk_sec_next  = req.second_bcd;
            clk_wday_next = req.weekday;
          end
          REQ_ADD: begin
            if (full) status_next = ST_FULL;
            else      pos_next    = count;
          end
          REQ_ERASE: begin
            if (idx_bad) begin
              status_next = ST_BAD_INDEX;
            end else if (idx_used) begin
              pos_next = CNT_W'(req.entry_index);
              if (!idx_moves) count_next = count - CNT_W'(1);
            end
          end
          REQ_CLEAR:  count_next = '0;
          REQ_MANUAL: manual_ring_next = req.manual_on;
          default: ;
        endcase
      end
      S_INS_RD: rd_addr = IDX_W'(pos - CNT_W'(1));
      S_INS_CMP: begin
        if (key_gt) begin
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = pos - CNT_W'(1);
        end
      end
      S_INS_PUT: begin
        wr_en      = 1'b1;
        count_next = count + CNT_W'(1);
      end
      S_DEL_RD: rd_addr = IDX_W'(pos + CNT_W'(1));
      S_DEL_WR: begin
        wr_en    = 1'b1;
        wr_data  = rd_data;
        pos_next = pos + CNT_W'(1);
        if (!del_more) count_next = count - CNT_W'(1);
      end
      S_SCAN: begin
        // read one entry per cycle, compare the one read the cycle before
        scan_vld_next = (pos < count);
        if (pos < count) pos_next = pos + CNT_W'(1);
        if (scan_vld && rd_data.hour == clk_hour && rd_data.minute == clk_min)
          match_next = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next         = 1'b1;
          out_data_next.bell_on  = (day_ok && match && ({3'b0, ring_seconds} >= clk_sec)) ||
                                   manual_ring;
          out_data_next.status     = status;
          out_data_next.now_hour   = clk_hour;
          out_data_next.now_minute = clk_min;
          out_data_next.now_second = clk_sec;
        end
      end
      default: ;
    endcase

    if (state != S_SCAN && state_next == S_SCAN) begin
      pos_next      = '0;
      scan_vld_next = 1'b0;
      match_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      clk_sec      <= '0;
      clk_min      <= '0;
      clk_hour     <= '0;
      clk_wday     <= 3'd1;
      manual_ring  <= 1'b0;
      count        <= '0;
      ring_mode    <= '0;
      ring_seconds <= RING_SECONDS_RST;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      clk_sec     <= clk_sec_next;
      clk_min     <= clk_min_next;
      clk_hour    <= clk_hour_next;
      clk_wday    <= clk_wday_next;
      manual_ring <= manual_ring_next;
      count       <= count_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RING_MODE:    ring_mode    <= cfg_data[1:0];
          REG_RING_SECONDS: ring_seconds <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) req <= in_data;
    pos      <= pos_next;
    status   <= status_next;
    match    <= match_next;
    scan_vld <= scan_vld_next;
    out_data <= out_data_next;
  end

endmodule
